// ===== hdl/pfra_pkg.sv =====
// types, constants and helpers shared by the page frame allocator
package pfra_pkg;

  localparam int FRAMES         = 32768;
  localparam int RESERVED_START = 160;
  localparam int RESERVED_END   = 1024;

  localparam int FRAME_W = 15;
  localparam int COUNT_W = 16;
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FC_W    = $clog2(FRAMES + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_ALLOCATE = 2'd0,
    KIND_FREE     = 2'd1,
    KIND_RETAIN   = 2'd2,
    KIND_RELEASE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_IN_USE       = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_BAD_DEC      = 3'd4,
    ST_OVERFLOW     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [FRAME_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] granted_frame;
    status_t            status;
    logic               released;
  } rsp_t;

  typedef struct packed {
    logic [IDX_W-1:0]   link;
    logic [COUNT_W-1:0] count;
    logic               on_list;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic is_reserved(input logic [IDX_W-1:0] f);
    return (32'(f) >= RESERVED_START) && (32'(f) < RESERVED_END);
  endfunction

endpackage

// ===== hdl/page_frame_refcount_allocator_core.sv =====
// page frame allocator: lifo free list with per-frame use counts in one ram
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req (kind, frame)
//  rsp     | out       | rsp_valid, rsp_stall | rsp (granted_frame, status, released)
//
// each item passes through two steps: accept and ram read, then modify, write back and
// register the result; a new item is accepted only after the last one has finished
// after reset a clearing pass writes every entry, one a cycle,
// with req_stall high during it
// a waiting result does not block the next accept; the write back waits
// while the result register is still full and stalled
module page_frame_refcount_allocator_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  pfra_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pfra_pkg::rsp_t rsp
);
  import pfra_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] init_idx;
  logic [IDX_W-1:0] free_head, free_head_next;
  logic [FC_W-1:0]  free_count, free_count_next;
  req_t             cur;
  logic [IDX_W-1:0] addr;

  logic             req_fire, exec_done, slot_free;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr, req_addr;
  entry_t           wentry, rentry;
  logic [ENTRY_W-1:0] rdata;
  rsp_t             rsp_new;
  logic             frame_oob;

  assign req_fire  = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_addr  = (req.kind == KIND_ALLOCATE) ? free_head : IDX_W'(req.frame);
  assign raddr     = req_fire ? req_addr : addr;
  assign rentry    = entry_t'(rdata);
  assign frame_oob = 32'(cur.frame) >= FRAMES;

  pfra_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_idx   <= '0;
      free_head  <= '0;
      free_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      free_count <= free_count_next;
      if (state == S_INIT) begin
        init_idx <= init_idx + IDX_W'(1);
      end
      if (exec_done) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur  <= req;
      addr <= req_addr;
    end
    if (exec_done) begin
      rsp <= rsp_new;
    end
  end

  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    free_count_next = free_count;
    req_stall       = (state != S_IDLE);
    exec_done       = 1'b0;
    we              = 1'b0;
    waddr           = addr;
    wentry          = rentry;
    rsp_new         = '{granted_frame: '0, status: ST_OK, released: 1'b0};

    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = init_idx;
        if (is_reserved(init_idx)) begin
          wentry = '{link: '0, count: COUNT_W'(1), on_list: 1'b0};
        end else begin
          wentry          = '{link: free_head, count: '0, on_list: 1'b1};
          free_head_next  = init_idx;
          free_count_next = free_count + FC_W'(1);
        end
        if (32'(init_idx) == FRAMES - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        exec_done = slot_free;
        priority if (cur.kind == KIND_ALLOCATE) begin
          if (free_count == '0) begin
            rsp_new.status = ST_EMPTY;
          end else begin
            rsp_new.granted_frame = FRAME_W'(free_head);
            free_head_next        = rentry.link;
            free_count_next       = free_count - FC_W'(1);
            we                    = 1'b1;
            wentry.link           = '0;
            wentry.on_list        = 1'b0;
          end
        end else if (frame_oob) begin
          rsp_new.status = ST_BAD_DEC;
        end else if (cur.kind == KIND_FREE) begin
          if (rentry.count != '0) begin
            rsp_new.status = ST_IN_USE;
          end else if (rentry.on_list) begin
            rsp_new.status = ST_ALREADY_FREE;
          end else begin
            we              = 1'b1;
            wentry.link     = free_head;
            wentry.on_list  = 1'b1;
            free_head_next  = addr;
            free_count_next = free_count + FC_W'(1);
          end
        end else if (cur.kind == KIND_RETAIN) begin
          if (rentry.count == COUNT_MAX) begin
            rsp_new.status = ST_OVERFLOW;
          end else begin
            we           = 1'b1;
            wentry.count = rentry.count + COUNT_W'(1);
          end
        end else begin
          if (rentry.count == '0) begin
            rsp_new.status = ST_BAD_DEC;
          end else if (rentry.count == COUNT_W'(1)) begin
            if (rentry.on_list) begin
              rsp_new.status = ST_ALREADY_FREE;
            end else begin
              we               = 1'b1;
              wentry.link      = free_head;
              wentry.count     = '0;
              wentry.on_list   = 1'b1;
              free_head_next   = addr;
              free_count_next  = free_count + FC_W'(1);
              rsp_new.released = 1'b1;
            end
          end else begin
            we           = 1'b1;
            wentry.count = rentry.count - COUNT_W'(1);
          end
        end
        if (!slot_free) begin
          we              = 1'b0;
          free_head_next  = free_head;
          free_count_next = free_count;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(free_count) <= FRAMES)
    else $error("free count exceeds frame total");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == S_EXEC)
    else $error("accepted item did not enter execution");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_INIT) || exec_done)
    else $error("ram write outside init sweep or write back");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_EXEC)
    else $error("result raised without an executed item");

endmodule

// ===== hdl/pfra_ram.sv =====
// generic single-port-write, registered-read ram
module pfra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
